[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define UCTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property, checked through reset as well.
`define UCTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/uctb_pkg.sv]
package uctb_pkg;

  localparam int MAX_TDS = 32;

  localparam int MpsW  = 7;
  localparam int WordW = 32;
  localparam int LenW  = 16;
  localparam int IdxW  = 8;

  localparam logic [MpsW-1:0] MPS_RESET = 7'd8;
  localparam logic [MpsW-1:0] MPS_LIMIT = 7'd64;

  localparam logic [IdxW-1:0] REG_MAX_PACKET_SIZE = 8'd0;
  localparam logic [IdxW-1:0] REG_TD_POOL_BASE    = 8'd1;

  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'he1;
  localparam logic [7:0] PID_SETUP = 8'h2d;

  localparam logic [WordW-1:0] LINK_TERM  = 32'h1;
  localparam logic [WordW-1:0] LINK_DEPTH = 32'h4;
  localparam logic [WordW-1:0] TD_STRIDE  = 32'd32;

  localparam logic [10:0] LEN_SETUP  = 11'd7;
  localparam logic [10:0] LEN_STATUS = 11'h7ff;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_SETUP,
    STEP_DATA,
    STEP_STATUS,
    STEP_OVF
  } step_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SETUP,
    EMIT_DATA,
    EMIT_STATUS,
    EMIT_OVF
  } emit_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_OVF,
    COND_HAS_DATA,
    COND_MORE
  } cond_e;

  typedef struct packed {
    emit_e emit;
    cond_e cond;
    step_e tgt_true;
    step_e tgt_false;
  } ucode_t;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(step_e pc);
    ucode_t w;
    unique case (pc)
      STEP_IDLE:   w = '{EMIT_NONE,   COND_ACCEPT,   STEP_CHECK, STEP_IDLE};
      STEP_CHECK:  w = '{EMIT_NONE,   COND_OVF,      STEP_OVF,   STEP_SETUP};
      STEP_SETUP:  w = '{EMIT_SETUP,  COND_HAS_DATA, STEP_DATA,  STEP_STATUS};
      STEP_DATA:   w = '{EMIT_DATA,   COND_MORE,     STEP_DATA,  STEP_STATUS};
      STEP_STATUS: w = '{EMIT_STATUS, COND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
      STEP_OVF:    w = '{EMIT_OVF,    COND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
      default:     w = '{EMIT_NONE,   COND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/uctb_if.sv]
interface uctb_req_if;
  logic        valid;
  logic        ready;
  logic [6:0]  device_address;
  logic        low_speed;
  logic [7:0]  request_type;
  logic [15:0] data_length;
  logic [31:0] data_address;
  logic [31:0] setup_address;

  modport source (
    output valid, device_address, low_speed, request_type, data_length,
           data_address, setup_address,
    input  ready
  );
  modport sink (
    input  valid, device_address, low_speed, request_type, data_length,
           data_address, setup_address,
    output ready
  );
endinterface

interface uctb_desc_if;
  logic        valid;
  logic        ready;
  logic [31:0] descriptor_address;
  logic [31:0] link_word;
  logic [31:0] status_word;
  logic [31:0] token_word;
  logic [31:0] buffer_word;
  logic        last_descriptor;
  logic        overflow;

  modport source (
    output valid, descriptor_address, link_word, status_word, token_word,
           buffer_word, last_descriptor, overflow,
    input  ready
  );
  modport sink (
    input  valid, descriptor_address, link_word, status_word, token_word,
           buffer_word, last_descriptor, overflow,
    output ready
  );
endinterface

interface uctb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/usb_control_td_chain_builder.sv]
// UHCI control transfer descriptor chain builder.
// req_i  : one control request per item (address, speed, bmRequestType,
//          data length, data and setup buffer addresses).
// desc_o : one item per transfer descriptor: SETUP, data packets of at most
//          max_packet_size bytes, then the zero-length status descriptor.
//          A request that needs more than MAX_TDS descriptors gives a single
//          item with overflow and last_descriptor set, all words zero.
// cfg_i  : register writes, always ready; index 0 max_packet_size,
//          index 1 td_pool_base. Write only while no request is in flight.
// Flow   : a microcoded sequencer walks a six-word control store. A request
//          takes an idle step, a limit check, then one step per descriptor
//          (or the overflow step). The next request is taken once the status
//          or overflow item has entered the output register.
// Stall  : descriptors wait in a single output register; while it is full and
//          desc_o.ready is low, an emitting step holds.
// Reset  : max_packet_size returns to 8, td_pool_base to 0, output empty.
`include "assert_macros.svh"

module usb_control_td_chain_builder (
  input  logic clk_i,
  input  logic rst_ni,
  uctb_req_if.sink    req_i,
  uctb_desc_if.source desc_o,
  uctb_cfg_if.sink    cfg_i
);
  import uctb_pkg::*;

  localparam int MaxDataTds = MAX_TDS - 2;
  localparam int ThrW       = MpsW + $clog2(MAX_TDS);
  localparam int CmpW       = (ThrW > LenW) ? ThrW + 1 : LenW + 1;

  // configuration
  logic [MpsW-1:0]  mps_cfg_q;
  logic [WordW-1:0] base_cfg_q;

  // sequencer
  step_e  pc_q, pc_d;
  ucode_t uw;
  logic   cond_ok, emit_fire, advance;

  // datapath
  logic [6:0]       addr7_q;
  logic             ls_q;
  logic             to_host_q;
  logic [LenW-1:0]  left_q, left_d;
  logic [WordW-1:0] dbuf_q;
  logic [WordW-1:0] sbuf_q;
  logic [WordW-1:0] here_q;
  logic             toggle_q;

  logic [MpsW-1:0]  mps_eff;
  logic [ThrW-1:0]  thr;
  logic             ovf;
  logic [MpsW-1:0]  sz;
  logic             last;
  logic [WordW-1:0] cs_word;

  // output register
  logic             out_valid_q;
  logic [WordW-1:0] o_addr_q, o_link_q, o_status_q, o_token_q, o_buf_q;
  logic             o_last_q, o_ovf_q;
  logic [WordW-1:0] o_link_d, o_token_d, o_buf_d;
  logic [10:0]      len_enc;
  logic [7:0]       pid;
  logic             tog;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mps_cfg_q  <= MPS_RESET;
      base_cfg_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_MAX_PACKET_SIZE) begin
        mps_cfg_q <= cfg_i.data[MpsW-1:0];
      end else if (cfg_i.index == REG_TD_POOL_BASE) begin
        base_cfg_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    if (mps_cfg_q == '0) begin
      mps_eff = MpsW'(1);
    end else if (mps_cfg_q > MPS_LIMIT) begin
      mps_eff = MPS_LIMIT;
    end else begin
      mps_eff = mps_cfg_q;
    end
  end

  assign thr     = ThrW'(mps_eff) * ThrW'(MaxDataTds);
  assign ovf     = CmpW'(left_q) > CmpW'(thr);
  assign sz      = (left_q > LenW'(mps_eff)) ? mps_eff : left_q[MpsW-1:0];
  assign left_d  = left_q - LenW'(sz);
  assign cs_word = {3'b000, 2'b11, ls_q, 2'b00, 1'b1, 23'd0};

  assign req_i.ready = (pc_q == STEP_IDLE);

  // sequencer step
  always_comb begin
    uw = ucode_rom(pc_q);
    case (uw.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_ACCEPT:   cond_ok = req_i.valid;
      COND_OVF:      cond_ok = ovf;
      COND_HAS_DATA: cond_ok = (left_q != '0);
      COND_MORE:     cond_ok = (left_d != '0);
      default:       cond_ok = 1'b0;
    endcase
    emit_fire = (uw.emit != EMIT_NONE) && (!out_valid_q || desc_o.ready);
    advance   = (uw.emit == EMIT_NONE) || emit_fire;
    pc_d      = pc_q;
    if (advance) begin
      pc_d = cond_ok ? uw.tgt_true : uw.tgt_false;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      addr7_q   <= req_i.device_address;
      ls_q      <= req_i.low_speed;
      to_host_q <= req_i.request_type[7];
      left_q    <= req_i.data_length;
      dbuf_q    <= req_i.data_address;
      sbuf_q    <= req_i.setup_address;
      here_q    <= {base_cfg_q[WordW-1:4], 4'b0000};
      toggle_q  <= 1'b1;
    end else if (emit_fire) begin
      here_q <= here_q + TD_STRIDE;
      if (uw.emit == EMIT_DATA) begin
        left_q   <= left_d;
        dbuf_q   <= dbuf_q + WordW'(sz);
        toggle_q <= ~toggle_q;
      end
    end
  end

  // descriptor fields
  always_comb begin
    last    = 1'b0;
    len_enc = LEN_SETUP;
    pid     = PID_SETUP;
    tog     = 1'b0;
    o_buf_d = sbuf_q;
    unique case (uw.emit)
      EMIT_DATA: begin
        len_enc = 11'(sz - MpsW'(1));
        pid     = to_host_q ? PID_IN : PID_OUT;
        tog     = toggle_q;
        o_buf_d = dbuf_q;
      end
      EMIT_STATUS: begin
        last    = 1'b1;
        len_enc = LEN_STATUS;
        pid     = to_host_q ? PID_OUT : PID_IN;
        tog     = 1'b1;
        o_buf_d = '0;
      end
      EMIT_OVF: begin
        last = 1'b1;
      end
      default: begin
      end
    endcase
    o_link_d  = last ? LINK_TERM : ((here_q + TD_STRIDE) | LINK_DEPTH);
    o_token_d = {len_enc, 1'b0, tog, 4'b0000, addr7_q, pid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (desc_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      o_last_q <= last;
      if (uw.emit == EMIT_OVF) begin
        o_ovf_q    <= 1'b1;
        o_addr_q   <= '0;
        o_link_q   <= '0;
        o_status_q <= '0;
        o_token_q  <= '0;
        o_buf_q    <= '0;
      end else begin
        o_ovf_q    <= 1'b0;
        o_addr_q   <= here_q;
        o_link_q   <= o_link_d;
        o_status_q <= cs_word;
        o_token_q  <= o_token_d;
        o_buf_q    <= o_buf_d;
      end
    end
  end

  assign desc_o.valid              = out_valid_q;
  assign desc_o.descriptor_address = o_addr_q;
  assign desc_o.link_word          = o_link_q;
  assign desc_o.status_word        = o_status_q;
  assign desc_o.token_word         = o_token_q;
  assign desc_o.buffer_word        = o_buf_q;
  assign desc_o.last_descriptor    = o_last_q;
  assign desc_o.overflow           = o_ovf_q;

  `UCTB_ASSERT(a_ovf_is_last, desc_o.valid && desc_o.overflow |-> desc_o.last_descriptor,
               "overflow item without last_descriptor")
  `UCTB_ASSERT(a_accept_to_check, req_i.valid && req_i.ready |=> pc_q == STEP_CHECK,
               "accepted request did not enter the limit check")
  `UCTB_ASSERT(a_data_nonempty, pc_q == STEP_DATA |-> left_q != '0,
               "data step entered with no bytes left")
  `UCTB_ASSERT(a_toggle_flip, emit_fire && uw.emit == EMIT_DATA |=> toggle_q != $past(toggle_q),
               "data toggle did not alternate")
endmodule
